### hw/rtl/mmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmp_pkg: shared types and constants of the MIDI message parser
// Byte codes, message kinds and the result record passed between stages.
// ----------------------------------------------------------------------------
package mmp_pkg;

  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CONTROL  = 2'd2,
    KIND_OTHER    = 2'd3
  } msg_kind_e;

  localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
  localparam logic [7:0] BYTE_COMMON_MIN   = 8'hF1;
  localparam logic [7:0] NO_STATUS         = 8'h00;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_CONTROL   = 4'hB;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_CHAN_PRES = 4'hD;

  typedef struct packed {
    msg_kind_e  kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } result_t;

  typedef struct packed {
    logic [7:0] midi_byte;
    logic       buffer_end;
  } item_t;

endpackage

### hw/rtl/midi_message_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_message_parser: MIDI byte stream to channel message parser
// Rebuilds note, control and other channel messages using running status.
// ----------------------------------------------------------------------------
// a message is offered on the output once its last byte has passed the input
//   register and then the result register
// throughput: one byte per cycle; the input stalls only while a result waits
// reset: asynchronous, clears running status, held byte, sysex flag, valids
module midi_message_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] midi_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] msg_kind_o,
  output logic [3:0] channel_o,
  output logic [6:0] first_data_o,
  output logic [6:0] second_data_o
);
  import mmp_pkg::*;

  item_t   in_item, s1_item;
  logic    s1_valid, s2_ready, fire, emit;
  result_t result, result_q, result_d;
  logic    out_valid_q, out_valid_d;

  assign in_item  = '{midi_byte: midi_byte_i, buffer_end: buffer_end_i};
  assign s2_ready = !out_valid_q || !out_stall_i;
  assign fire     = s1_valid && s2_ready;

  mmp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (fire),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  mmp_parse_core u_parse_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item),
    .emit_o   (emit),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (s2_ready) begin
      out_valid_d = fire && emit;
      if (fire && emit) begin
        result_d = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o   = out_valid_q;
  assign msg_kind_o    = result_q.kind;
  assign channel_o     = result_q.channel;
  assign first_data_o  = result_q.first_data;
  assign second_data_o = result_q.second_data;

endmodule

### hw/rtl/mmp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmp_in_stage: input register of the MIDI message parser
// Captures one byte per transaction and holds it until the parse stage moves.
// ----------------------------------------------------------------------------
module mmp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mmp_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output mmp_pkg::item_t item_o
);
  import mmp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hw/rtl/mmp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmp_parse_core: running status state and byte decode
// Updates running status, held data byte and sysex flag for one byte.
// ----------------------------------------------------------------------------
module mmp_parse_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  mmp_pkg::item_t   item_i,
  output logic             emit_o,
  output mmp_pkg::result_t result_o
);
  import mmp_pkg::*;

  logic [7:0] status_q, status_d;
  logic [6:0] held_q, held_d;
  logic       held_valid_q, held_valid_d;
  logic       in_sysex_q, in_sysex_d;
  logic [7:0] b;
  logic [3:0] hi;
  msg_kind_e  kind;

  assign b  = item_i.midi_byte;
  assign hi = status_q[7:4];

  always_comb begin
    status_d     = status_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    in_sysex_d   = in_sysex_q;
    emit_o       = 1'b0;
    result_o     = '{kind: KIND_OTHER, channel: status_q[3:0],
                     first_data: b[6:0], second_data: 7'd0};

    case (hi)
      HI_NOTE_ON:  kind = (b[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
      HI_NOTE_OFF: kind = KIND_NOTE_OFF;
      HI_CONTROL:  kind = KIND_CONTROL;
      default:     kind = KIND_OTHER;
    endcase

    if (b >= BYTE_REALTIME_MIN) begin
      // realtime bytes leave the parse state untouched, unless they end the buffer
    end else if (in_sysex_q) begin
      if (b == BYTE_SYSEX_END) begin
        in_sysex_d = 1'b0;
      end
    end else if (b[7]) begin
      held_valid_d = 1'b0;
      if (b == BYTE_SYSEX_START) begin
        in_sysex_d = 1'b1;
        status_d   = NO_STATUS;
      end else if (b >= BYTE_COMMON_MIN) begin
        status_d = NO_STATUS;
      end else begin
        status_d = b;
      end
    end else if (status_q == NO_STATUS) begin
      // stray data byte
    end else if (hi == HI_PROGRAM || hi == HI_CHAN_PRES) begin
      emit_o = 1'b1;
    end else if (!held_valid_q) begin
      held_d       = b[6:0];
      held_valid_d = 1'b1;
    end else begin
      emit_o       = 1'b1;
      result_o     = '{kind: kind, channel: status_q[3:0],
                       first_data: held_q, second_data: b[6:0]};
      held_valid_d = 1'b0;
    end

    if (item_i.buffer_end) begin
      status_d     = NO_STATUS;
      held_d       = 7'd0;
      held_valid_d = 1'b0;
      in_sysex_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q     <= NO_STATUS;
      held_q       <= 7'd0;
      held_valid_q <= 1'b0;
      in_sysex_q   <= 1'b0;
    end else if (fire_i) begin
      status_q     <= status_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      in_sysex_q   <= in_sysex_d;
    end
  end

endmodule

### hw/rtl/mmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmp_checker: port level checks of the MIDI message parser
// Watches the handshakes and the message fields over time.
// ----------------------------------------------------------------------------
module mmp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] msg_kind_o,
  input logic [3:0] channel_o,
  input logic [6:0] first_data_o,
  input logic [6:0] second_data_o
);
  import mmp_pkg::*;

  // a stalled result transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(msg_kind_o) && $stable(channel_o)
      && $stable(first_data_o) && $stable(second_data_o))
    else $error("result payload changed while stalled");

  // the input only backs up behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // zero velocity note on is reported as note off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && msg_kind_o == KIND_NOTE_ON |-> second_data_o != 7'd0)
    else $error("note on with zero velocity");

endmodule

bind midi_message_parser mmp_checker u_mmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .msg_kind_o    (msg_kind_o),
  .channel_o     (channel_o),
  .first_data_o  (first_data_o),
  .second_data_o (second_data_o)
);
